// ===== src/cbcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbcs_pkg
// Types, codes and helpers shared by the boot client sequencer modules.
// ----------------------------------------------------------------------------
package cbcs_pkg;

   localparam int PAGE_BYTES  = 4096;
   localparam int PAGE_FRAMES = (PAGE_BYTES + 7) / 8;
   localparam int FRAMES_W    = $clog2(PAGE_FRAMES + 1);
   localparam int MAX_RES     = 3;
   localparam int CNT_W       = 2;

   // commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_FRAME = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_PROGRAM = 2'd2;
   localparam logic [1:0] KIND_BOOT    = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_UNIQUE_ID   = 3'd0;
   localparam logic [2:0] CSR_BOOT_CONFIG = 3'd1;
   localparam logic [2:0] CSR_BASE_ADDR   = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT     = 3'd3;
   localparam logic [2:0] CSR_TRIES       = 3'd4;

   localparam logic [63:0] RST_UNIQUE_ID   = 64'd0;
   localparam logic [7:0]  RST_BOOT_CONFIG = 8'h01;
   localparam logic [28:0] RST_BASE_ADDR   = 29'h1F123400;
   localparam logic [15:0] RST_TIMEOUT     = 16'd50000;
   localparam logic [3:0]  RST_TRIES       = 4'd4;

   localparam logic [28:0] REQ_BIT   = 29'h80;
   localparam logic [7:0]  LAST_PAGE = 8'hFF;
   localparam logic [3:0]  MAX_TRIES = 4'hF;

   typedef struct packed {
      logic [63:0] unique_id;
      logic [7:0]  boot_config;
      logic [28:0] base_address;
      logic [15:0] reply_timeout;
      logic [3:0]  self_start_tries;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [28:0] tx_id;
      logic [3:0]  tx_length;
      logic [63:0] tx_payload;
      logic [11:0] byte_offset;
      logic [7:0]  page_index;
   } res_type;

   typedef struct packed {
      logic [CNT_W-1:0]          count;
      logic [6:0]                node_id;
      res_type [MAX_RES-1:0]     res;
   } bundle_type;

   function automatic res_type make_res(input logic [1:0] kind, input logic [28:0] id,
                                        input logic [3:0] len, input logic [63:0] data,
                                        input logic [11:0] offset, input logic [7:0] page);
      res_type r;
      r.kind        = kind;
      r.tx_id       = id;
      r.tx_length   = len;
      r.tx_payload  = data;
      r.byte_offset = offset;
      r.page_index  = page;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/cbcs_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbcs_csr
// Configuration registers of the boot client sequencer.
// ----------------------------------------------------------------------------
module cbcs_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [2:0]       csr_index,
   input  wire logic [63:0]      csr_write_data,
   output cbcs_pkg::cfg_type     cfg
);

   cbcs_pkg::cfg_type cfg_ff;
   cbcs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cbcs_pkg::CSR_UNIQUE_ID:   cfg_in.unique_id        = csr_write_data;
            cbcs_pkg::CSR_BOOT_CONFIG: cfg_in.boot_config      = csr_write_data[7:0];
            cbcs_pkg::CSR_BASE_ADDR:   cfg_in.base_address     = csr_write_data[28:0];
            cbcs_pkg::CSR_TIMEOUT:     cfg_in.reply_timeout    = csr_write_data[15:0];
            cbcs_pkg::CSR_TRIES:       cfg_in.self_start_tries = csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unique_id        <= cbcs_pkg::RST_UNIQUE_ID;
         cfg_ff.boot_config      <= cbcs_pkg::RST_BOOT_CONFIG;
         cfg_ff.base_address     <= cbcs_pkg::RST_BASE_ADDR;
         cfg_ff.reply_timeout    <= cbcs_pkg::RST_TIMEOUT;
         cfg_ff.self_start_tries <= cbcs_pkg::RST_TRIES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== src/cbcs_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbcs_core
// Session state and per-item step logic; builds the result bundle of an item.
// ----------------------------------------------------------------------------
module cbcs_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cbcs_pkg::cfg_type cfg,
   input  wire logic              accept,
   input  wire logic [1:0]        command,
   input  wire logic [28:0]       rx_id,
   input  wire logic [3:0]        rx_length,
   input  wire logic [63:0]       rx_payload,
   output cbcs_pkg::bundle_type   bundle
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_AWAIT,
      PH_DOWNLOAD,
      PH_BOOTED
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [15:0]                      tick_ff, tick_in;
   logic [3:0]                       tries_ff, tries_in;
   logic [6:0]                       id_ff, id_in;
   logic [7:0]                       page_ff, page_in;
   logic [cbcs_pkg::FRAMES_W-1:0]    frames_ff, frames_in;

   logic [28:0]                      req_addr;
   logic [16:0]                      tick_inc;
   logic [cbcs_pkg::FRAMES_W:0]      frames_inc;
   logic [31:0]                      offset_wide;
   logic                             reply_ok;
   logic                             data_ok;
   cbcs_pkg::res_type                boot_res;

   assign req_addr    = {cfg.base_address[28:7], 7'd0} | cbcs_pkg::REQ_BIT
                        | {21'd0, cfg.boot_config};
   assign tick_inc    = {1'b0, tick_ff} + 17'd1;
   assign frames_inc  = {1'b0, frames_ff} + (cbcs_pkg::FRAMES_W + 1)'(1);
   assign offset_wide = 32'(frames_ff) << 3;
   assign reply_ok    = (rx_id[28:7] == cfg.base_address[28:7]) && (rx_length == 4'd8)
                        && (rx_payload == cfg.unique_id);
   assign data_ok     = (rx_id == {cfg.base_address[28:7], id_ff}) && (rx_length == 4'd8);
   assign boot_res    = cbcs_pkg::make_res(cbcs_pkg::KIND_BOOT, 29'd0, 4'd0, 64'd0,
                                           12'd0, page_ff);

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      tries_in     = tries_ff;
      id_in        = id_ff;
      page_in      = page_ff;
      frames_in    = frames_ff;
      bundle.count = '0;
      bundle.res   = '0;

      unique case (command)
         cbcs_pkg::CMD_START: begin
            phase_in     = PH_AWAIT;
            tick_in      = '0;
            tries_in     = '0;
            id_in        = '0;
            page_in      = '0;
            frames_in    = '0;
            bundle.count = 2'd1;
            bundle.res[0] = cbcs_pkg::make_res(cbcs_pkg::KIND_TX, req_addr, 4'd8,
                                               cfg.unique_id, 12'd0, 8'd0);
         end
         cbcs_pkg::CMD_TICK: begin
            if (phase_ff == PH_AWAIT || phase_ff == PH_DOWNLOAD) begin
               if (tick_inc >= {1'b0, cfg.reply_timeout}) begin
                  tick_in      = '0;
                  bundle.count = 2'd1;
                  if (phase_ff == PH_DOWNLOAD) begin
                     phase_in      = PH_BOOTED;
                     bundle.res[0] = boot_res;
                  end else begin
                     if (tries_ff != cbcs_pkg::MAX_TRIES) begin
                        tries_in = tries_ff + 4'd1;
                     end
                     if (cfg.boot_config[7] && tries_in >= cfg.self_start_tries) begin
                        phase_in      = PH_BOOTED;
                        bundle.res[0] = boot_res;
                     end else begin
                        bundle.res[0] = cbcs_pkg::make_res(cbcs_pkg::KIND_TX, req_addr,
                                                           4'd8, cfg.unique_id, 12'd0,
                                                           page_ff);
                     end
                  end
               end else begin
                  tick_in = tick_inc[15:0];
               end
            end
         end
         cbcs_pkg::CMD_FRAME: begin
            if (phase_ff == PH_AWAIT && reply_ok) begin
               id_in        = rx_id[6:0];
               tick_in      = '0;
               bundle.count = 2'd1;
               if (rx_id[6:0] != 7'd0) begin
                  phase_in      = PH_DOWNLOAD;
                  page_in       = 8'd1;
                  frames_in     = '0;
                  bundle.res[0] = cbcs_pkg::make_res(cbcs_pkg::KIND_TX, req_addr, 4'd2,
                                                     {48'd0, 8'd1, 1'b0, rx_id[6:0]},
                                                     12'd0, 8'd1);
               end else begin
                  phase_in      = PH_BOOTED;
                  bundle.res[0] = boot_res;
               end
            end else if (phase_ff == PH_DOWNLOAD && data_ok) begin
               tick_in       = '0;
               bundle.res[0] = cbcs_pkg::make_res(cbcs_pkg::KIND_WRITE, 29'd0, 4'd0,
                                                  rx_payload, offset_wide[11:0], page_ff);
               if (frames_inc >= (cbcs_pkg::FRAMES_W + 1)'(cbcs_pkg::PAGE_FRAMES)) begin
                  // page full: program it, then next page or finish
                  frames_in     = '0;
                  bundle.count  = 2'd3;
                  bundle.res[1] = cbcs_pkg::make_res(cbcs_pkg::KIND_PROGRAM, 29'd0, 4'd0,
                                                     64'd0, 12'd0, page_ff);
                  if (page_ff == cbcs_pkg::LAST_PAGE) begin
                     phase_in      = PH_BOOTED;
                     bundle.res[2] = boot_res;
                  end else begin
                     page_in       = page_ff + 8'd1;
                     bundle.res[2] = cbcs_pkg::make_res(cbcs_pkg::KIND_TX, req_addr, 4'd2,
                                                        {48'd0, page_in, 1'b0, id_ff},
                                                        12'd0, page_in);
                  end
               end else begin
                  frames_in    = frames_inc[cbcs_pkg::FRAMES_W-1:0];
                  bundle.count = 2'd1;
               end
            end
         end
         default: ;
      endcase

      bundle.node_id = id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= '0;
         tries_ff  <= '0;
         id_ff     <= '0;
         page_ff   <= '0;
         frames_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         tries_ff  <= tries_in;
         id_ff     <= id_in;
         page_ff   <= page_in;
         frames_ff <= frames_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/cbcs_rsp_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbcs_rsp_buf
// Holds the results of one item and hands them out one per handshake.
// ----------------------------------------------------------------------------
module cbcs_rsp_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cbcs_pkg::bundle_type bundle,
   output logic                      push_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [28:0]               rsp_tx_id,
   output logic [3:0]                rsp_tx_length,
   output logic [63:0]               rsp_tx_payload,
   output logic [11:0]               rsp_byte_offset,
   output logic [7:0]                rsp_page_index,
   output logic [6:0]                rsp_node_id,
   output logic                      rsp_last
);

   cbcs_pkg::res_type [cbcs_pkg::MAX_RES-1:0] entries_ff;
   logic [cbcs_pkg::CNT_W-1:0]                rem_ff;
   logic [6:0]                                node_ff;
   logic                                      pop;

   assign rsp_valid  = (rem_ff != '0);
   assign pop        = rsp_valid && rsp_ready;
   // room once the last waiting result leaves
   assign push_ready = (rem_ff == '0) || (rem_ff == 2'd1 && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (push) begin
         rem_ff <= bundle.count;
      end else if (pop) begin
         rem_ff <= rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff <= bundle.res;
         node_ff    <= bundle.node_id;
      end else if (pop) begin
         for (int i = 0; i < cbcs_pkg::MAX_RES - 1; i++) begin
            entries_ff[i] <= entries_ff[i+1];
         end
      end
   end

   assign rsp_kind        = entries_ff[0].kind;
   assign rsp_tx_id       = entries_ff[0].tx_id;
   assign rsp_tx_length   = entries_ff[0].tx_length;
   assign rsp_tx_payload  = entries_ff[0].tx_payload;
   assign rsp_byte_offset = entries_ff[0].byte_offset;
   assign rsp_page_index  = entries_ff[0].page_index;
   assign rsp_node_id     = node_ff;
   assign rsp_last        = (rem_ff == 2'd1);

endmodule
`default_nettype wire

// ===== src/can_boot_client_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// can_boot_client_sequencer
// Client side of a CAN boot exchange: id request, page download, boot.
// ----------------------------------------------------------------------------
// first result: valid in the cycle after its item is accepted
// throughput: 1 item per cycle while each item gives at most one result and
//   rsp_ready is high; more results hold the single buffer until all are taken
// reset: registers to their defaults, session idle, result buffer empty
module can_boot_client_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [28:0] req_rx_id,
   input  wire logic [3:0]  req_rx_length,
   input  wire logic [63:0] req_rx_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [28:0]      rsp_tx_id,
   output logic [3:0]       rsp_tx_length,
   output logic [63:0]      rsp_tx_payload,
   output logic [11:0]      rsp_byte_offset,
   output logic [7:0]       rsp_page_index,
   output logic [6:0]       rsp_node_id,
   output logic             rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_write_data
);

   cbcs_pkg::cfg_type    cfg;
   cbcs_pkg::bundle_type bundle;
   logic                 accept;

   assign accept = req_valid && req_ready;

   cbcs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   cbcs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .command    (req_command),
      .rx_id      (req_rx_id),
      .rx_length  (req_rx_length),
      .rx_payload (req_rx_payload),
      .bundle     (bundle)
   );

   cbcs_rsp_buf u_rsp_buf (
      .clock           (clock),
      .reset           (reset),
      .push            (accept),
      .bundle          (bundle),
      .push_ready      (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_tx_id       (rsp_tx_id),
      .rsp_tx_length   (rsp_tx_length),
      .rsp_tx_payload  (rsp_tx_payload),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_page_index  (rsp_page_index),
      .rsp_node_id     (rsp_node_id),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// ===== verif/can_boot_client_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_boot_client_sequencer_tb
// Sends start, tick and received-frame items into the boot client sequencer.
// Every result is checked against an in-bench model of the boot exchange:
// id requests and retries, node id assignment, page download and boot.
// ----------------------------------------------------------------------------
module can_boot_client_sequencer_tb;

   localparam logic [28:0] BASE_MASK    = 29'h1FFFFF80;
   localparam logic [3:0]  FRAME_LEN    = 4'd8;
   localparam logic [3:0]  PAGE_REQ_LEN = 4'd2;
   localparam logic [1:0]  CMD_NONE     = 2'd3;  // undefined command, ignored
   localparam int          IDLE_PCT     = 38;
   localparam int          RANDOM_ITEMS = 30;

   typedef enum logic [1:0] {
      SESSION_IDLE, SESSION_WAIT_ID, SESSION_DOWNLOAD, SESSION_BOOTED
   } session_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [28:0] tx_id;
      logic [3:0]  tx_length;
      logic [63:0] tx_payload;
      logic [11:0] byte_offset;
      logic [7:0]  page_index;
      logic [6:0]  node_id;
      logic        last;
   } boot_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_NONE;
   logic [28:0] req_rx_id = '0;
   logic [3:0]  req_rx_length = '0;
   logic [63:0] req_rx_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [28:0] rsp_tx_id;
   logic [3:0]  rsp_tx_length;
   logic [63:0] rsp_tx_payload;
   logic [11:0] rsp_byte_offset;
   logic [7:0]  rsp_page_index;
   logic [6:0]  rsp_node_id;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = cbcs_pkg::CSR_UNIQUE_ID;
   logic [63:0] csr_write_data = '0;

   // model copy of the registers and the session state
   logic [63:0]  chip_id     = cbcs_pkg::RST_UNIQUE_ID;
   logic [7:0]   boot_cfg    = cbcs_pkg::RST_BOOT_CONFIG;
   logic [28:0]  base_addr   = cbcs_pkg::RST_BASE_ADDR;
   logic [15:0]  reply_limit = cbcs_pkg::RST_TIMEOUT;
   logic [3:0]   try_limit   = cbcs_pkg::RST_TRIES;
   session_type  session     = SESSION_IDLE;
   logic [15:0]  idle_ticks  = '0;
   logic [3:0]   tries_done  = '0;
   logic [6:0]   node        = '0;
   logic [7:0]   page        = '0;
   int           page_frames = 0;

   boot_result_type expected_results[$];
   int              active_items = 0;
   int              errors = 0;
   bit              stall_free = 1'b0;

   can_boot_client_sequencer i_dut (.*);

   always #5 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [28:0] request_id();
      return (base_addr & BASE_MASK) | cbcs_pkg::REQ_BIT | {21'd0, boot_cfg};
   endfunction

   function automatic logic [28:0] node_address(input logic [6:0] n);
      return (base_addr & BASE_MASK) | {22'd0, n};
   endfunction

   function automatic void expect_result(input logic [1:0] kind, input logic [28:0] id,
                                         input logic [3:0] len, input logic [63:0] data,
                                         input logic [11:0] offset);
      boot_result_type r;
      r.kind        = kind;
      r.tx_id       = id;
      r.tx_length   = len;
      r.tx_payload  = data;
      r.byte_offset = offset;
      r.page_index  = page;
      r.node_id     = node;
      r.last        = 1'b0;
      expected_results.push_back(r);
   endfunction

   function automatic void expect_id_request();
      expect_result(cbcs_pkg::KIND_TX, request_id(), FRAME_LEN, chip_id, '0);
   endfunction

   function automatic void expect_page_request();
      expect_result(cbcs_pkg::KIND_TX, request_id(), PAGE_REQ_LEN,
                    {48'd0, page, 1'b0, node}, '0);
   endfunction

   function automatic void expect_boot();
      session = SESSION_BOOTED;
      expect_result(cbcs_pkg::KIND_BOOT, '0, '0, '0, '0);
   endfunction

   // advances the session model by one accepted item and queues its results
   function automatic void predict_item(input logic [1:0] cmd, input logic [28:0] id,
                                        input logic [3:0] len, input logic [63:0] data);
      int          queued;
      logic [16:0] next_ticks;
      queued = expected_results.size();
      if (cmd == cbcs_pkg::CMD_START) begin
         session     = SESSION_WAIT_ID;
         idle_ticks  = '0;
         tries_done  = '0;
         node        = '0;
         page        = '0;
         page_frames = 0;
         active_items++;
         expect_id_request();
      end else if (cmd == cbcs_pkg::CMD_TICK &&
                   (session == SESSION_WAIT_ID || session == SESSION_DOWNLOAD)) begin
         active_items++;
         next_ticks = idle_ticks + 17'd1;
         if (next_ticks >= {1'b0, reply_limit}) begin
            idle_ticks = '0;
            if (session == SESSION_DOWNLOAD) begin
               expect_boot();
            end else begin
               if (tries_done != cbcs_pkg::MAX_TRIES) tries_done++;
               if (boot_cfg[7] && tries_done >= try_limit) expect_boot();
               else expect_id_request();
            end
         end else begin
            idle_ticks = next_ticks[15:0];
         end
      end else if (cmd == cbcs_pkg::CMD_FRAME && session == SESSION_WAIT_ID) begin
         if ((id & BASE_MASK) == (base_addr & BASE_MASK) && len == FRAME_LEN &&
             data == chip_id) begin
            active_items++;
            node       = id[6:0];
            idle_ticks = '0;
            if (node != 7'd0) begin
               session     = SESSION_DOWNLOAD;
               page        = 8'd1;
               page_frames = 0;
               expect_page_request();
            end else begin
               expect_boot();
            end
         end
      end else if (cmd == cbcs_pkg::CMD_FRAME && session == SESSION_DOWNLOAD) begin
         if (id == node_address(node) && len == FRAME_LEN) begin
            active_items++;
            expect_result(cbcs_pkg::KIND_WRITE, '0, '0, data, 12'(page_frames * 8));
            page_frames++;
            idle_ticks = '0;
            if (page_frames * 8 >= cbcs_pkg::PAGE_BYTES) begin
               expect_result(cbcs_pkg::KIND_PROGRAM, '0, '0, '0, '0);
               page_frames = 0;
               if (page >= cbcs_pkg::LAST_PAGE) begin
                  expect_boot();
               end else begin
                  page++;
                  expect_page_request();
               end
            end
         end
      end
      if (expected_results.size() > queued)
         expected_results[expected_results.size() - 1].last = 1'b1;
   endfunction

   task automatic issue_item(input logic [1:0] cmd, input logic [28:0] id,
                             input logic [3:0] len, input logic [63:0] data);
      while (!stall_free && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_rx_id      <= id;
      req_rx_length  <= len;
      req_rx_payload <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(cmd, id, len, data);
   endtask

   task automatic start_session();
      issue_item(cbcs_pkg::CMD_START, 29'($urandom), 4'($urandom), rand64());
   endtask

   task automatic timer_tick();
      issue_item(cbcs_pkg::CMD_TICK, 29'($urandom), 4'($urandom), rand64());
   endtask

   task automatic send_frame(input logic [28:0] id, input logic [3:0] len,
                             input logic [63:0] data);
      issue_item(cbcs_pkg::CMD_FRAME, id, len, data);
   endtask

   // wait for all results, plus a margin for items that give none
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [63:0] uid, input logic [7:0] cfg,
                                 input logic [28:0] base, input logic [15:0] timeout,
                                 input logic [3:0] tries);
      csr_write_enable <= 1'b1;
      csr_index <= cbcs_pkg::CSR_UNIQUE_ID;
      csr_write_data <= uid;
      @(posedge clock);
      csr_index <= cbcs_pkg::CSR_BOOT_CONFIG;
      csr_write_data <= 64'(cfg);
      @(posedge clock);
      csr_index <= cbcs_pkg::CSR_BASE_ADDR;
      csr_write_data <= 64'(base);
      @(posedge clock);
      csr_index <= cbcs_pkg::CSR_TIMEOUT;
      csr_write_data <= 64'(timeout);
      @(posedge clock);
      csr_index <= cbcs_pkg::CSR_TRIES;
      csr_write_data <= 64'(tries);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      chip_id     = uid;
      boot_cfg    = cfg;
      base_addr   = base;
      reply_limit = timeout;
      try_limit   = tries;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : result_check
      boot_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: kind %0d", rsp_kind);
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("tx_id", want.tx_id, rsp_tx_id);
            check_field("tx_length", want.tx_length, rsp_tx_length);
            check_field("tx_payload", want.tx_payload, rsp_tx_payload);
            check_field("byte_offset", want.byte_offset, rsp_byte_offset);
            check_field("page_index", want.page_index, rsp_page_index);
            check_field("node_id", want.node_id, rsp_node_id);
            check_field("last", want.last, rsp_last);
         end
      end
      rsp_ready <= stall_free || ($urandom_range(99) >= IDLE_PCT);
   end

   // register defaults, idle items ignored, restart from download
   task automatic test_reset_defaults();
      timer_tick();
      send_frame(node_address(7'd5), FRAME_LEN, rand64());
      issue_item(CMD_NONE, 29'($urandom), 4'($urandom), rand64());
      start_session();
      send_frame(cbcs_pkg::RST_BASE_ADDR | 29'h5, FRAME_LEN, cbcs_pkg::RST_UNIQUE_ID);
      send_frame(node_address(7'd5), FRAME_LEN, rand64());
      timer_tick();
      start_session();
      settle();
   endtask

   task automatic test_self_start_limit();
      apply_settings(rand64(), 8'h80, 29'h0, 16'd3, 4'd3);
      start_session();
      // two retries, then boot with no node id
      repeat (9) timer_tick();
      timer_tick();
      send_frame(29'h9, FRAME_LEN, chip_id);
      issue_item(CMD_NONE, 29'($urandom), 4'($urandom), rand64());
      settle();
      // zero tries behaves as one
      apply_settings(rand64(), 8'hFF, 29'h1FFFFFFF, 16'd1, 4'd0);
      start_session();
      timer_tick();
      settle();
      // zero timeout: every tick expires
      apply_settings(rand64(), 8'h81, 29'($urandom), 16'd0, 4'd2);
      start_session();
      timer_tick();
      timer_tick();
      settle();
   endtask

   task automatic test_endless_retry();
      apply_settings('1, 8'h00, 29'h0, 16'd1, 4'd15);
      start_session();
      repeat (16) timer_tick();
      settle();
      // retry count should sit at its ceiling, so self-start ends it now
      apply_settings('1, 8'h80, 29'h0, 16'd1, 4'd15);
      timer_tick();
      settle();
   endtask

   task automatic test_reply_filter();
      apply_settings(rand64(), 8'($urandom_range(0, 127)), 29'h1FFFFFFF, 16'hFFFF, 4'd1);
      start_session();
      send_frame(29'h1FFFFF85 ^ 29'h100, FRAME_LEN, chip_id);
      send_frame(29'h1FFFFF85, 4'd7, chip_id);
      send_frame(29'h1FFFFF85, 4'd15, chip_id);
      send_frame(29'h1FFFFF85, FRAME_LEN, chip_id ^ 64'h8000_0000_0000_0000);
      // node id zero boots without a download
      send_frame(29'h1FFFFF80, FRAME_LEN, chip_id);
      start_session();
      send_frame(29'h1FFFFFFF, FRAME_LEN, chip_id);
      send_frame(node_address(7'h7E), FRAME_LEN, rand64());
      send_frame(node_address(7'h7F), 4'd0, rand64());
      send_frame(node_address(7'h7F), FRAME_LEN, '0);
      send_frame(node_address(7'h7F), FRAME_LEN, '1);
      timer_tick();
      start_session();
      settle();
   endtask

   task automatic test_download_timeout();
      apply_settings(rand64(), 8'h01, 29'($urandom), 16'd2, 4'd4);
      start_session();
      send_frame(node_address(7'h11), FRAME_LEN, chip_id);
      timer_tick();
      send_frame(node_address(7'h11), FRAME_LEN, rand64());
      timer_tick();
      // unwanted frame leaves the timer running
      send_frame(node_address(7'h11), 4'd9, rand64());
      timer_tick();
      settle();
   endtask

   // download writes back to back with no stalls on either side
   task automatic test_back_to_back();
      apply_settings(rand64(), 8'h01, 29'($urandom), 16'hFFFF, 4'd4);
      stall_free = 1'b1;
      start_session();
      send_frame(node_address(7'h01), FRAME_LEN, chip_id);
      repeat (20) send_frame(node_address(7'h01), FRAME_LEN, rand64());
      timer_tick();
      start_session();
      settle();
      stall_free = 1'b0;
   endtask

   task automatic test_random_sessions();
      int          goal;
      int          pick;
      int          bit_pos;
      logic [63:0] uid;
      logic [28:0] id;
      logic [3:0]  len;
      logic [63:0] data;
      goal = active_items + RANDOM_ITEMS;
      while (active_items < goal) begin
         case ($urandom_range(7))
            0:       uid = '0;
            1:       uid = '1;
            default: uid = rand64();
         endcase
         apply_settings(uid, 8'($urandom), 29'($urandom), 16'($urandom_range(1, 6)),
                        4'($urandom_range(0, 15)));
         start_session();
         repeat ($urandom_range(4, 16)) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               // the item the session is waiting for
               if (session == SESSION_WAIT_ID)
                  send_frame(node_address(($urandom_range(7) == 0) ? 7'd0 : 7'($urandom)),
                             FRAME_LEN, chip_id);
               else if (session == SESSION_DOWNLOAD)
                  send_frame(node_address(node), FRAME_LEN, rand64());
               else
                  start_session();
            end else if (pick < 70) begin
               timer_tick();
            end else if (pick < 85) begin
               // nearly right frame
               id   = (session == SESSION_DOWNLOAD) ? node_address(node)
                                                     : node_address(7'($urandom));
               len  = FRAME_LEN;
               data = chip_id;
               case ($urandom_range(2))
                  0: begin
                     bit_pos     = $urandom_range(28);
                     id[bit_pos] = ~id[bit_pos];
                  end
                  1: begin
                     bit_pos       = $urandom_range(63);
                     data[bit_pos] = ~data[bit_pos];
                  end
                  default: len = 4'($urandom);
               endcase
               send_frame(id, len, data);
            end else if (pick < 95) begin
               issue_item(2'($urandom), 29'($urandom), 4'($urandom), rand64());
            end else begin
               start_session();
            end
         end
         settle();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_self_start_limit();
      test_endless_retry();
      test_reply_filter();
      test_download_timeout();
      test_back_to_back();
      test_random_sessions();
      settle();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("can_boot_client_sequencer_tb OK");
      end else begin
         $display("can_boot_client_sequencer_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("can_boot_client_sequencer_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/cbcs_pkg.sv
src/cbcs_csr.sv
src/cbcs_core.sv
src/cbcs_rsp_buf.sv
src/can_boot_client_sequencer.sv
verif/can_boot_client_sequencer_tb.sv
